// ===== hw/rtl/dheap_pkg.sv =====
// Shared types and constants for the d-ary min-heap queue.
`timescale 1ns / 1ps
package dheap_pkg;
    localparam int CAPACITY_DEF  = 1024;
    localparam int MAX_ORDER_DEF = 8;
    localparam int KEY_W   = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int ORDER_W = 4;
    localparam int FILL_W  = 11;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd2;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_PEEK   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CHANGE = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;
endpackage

// ===== hw/rtl/dheap_in_if.sv =====
// Input channel: operation words.
`timescale 1ns / 1ps
interface dheap_in_if
    import dheap_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] new_key;
    modport source (output valid, kind, key, new_key, input ready);
    modport sink   (input valid, kind, key, new_key, output ready);
endinterface

// ===== hw/rtl/dheap_out_if.sv =====
// Output channel: result words.
`timescale 1ns / 1ps
interface dheap_out_if
    import dheap_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] result_key;
    logic [STAT_W-1:0]       status;
    logic [FILL_W-1:0]       fill_count;
    modport source (output valid, result_key, status, fill_count, input ready);
    modport sink   (input valid, result_key, status, fill_count, output ready);
endinterface

// ===== hw/rtl/dheap_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dheap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/d_ary_min_heap_queue.sv =====
// Top level of the d-ary min-heap priority queue.
`timescale 1ns / 1ps
// One operation word at a time; one result word per operation. Keys sit in a single-port
// RAM with registered read. Peek reads the root; insert sifts the new key up; remove sifts
// the last key down from the root; change key scans the store key by key up to the match
// (through every stored key on a miss), then sifts as insert or remove do. The result
// register frees the input as soon as it is loaded.
module d_ary_min_heap_queue
    import dheap_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ORDER_W-1:0] cfg_wdata,
    dheap_in_if.sink           in_ch,
    dheap_out_if.source        out_ch
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int PW = CW + OW + 1;
    // reciprocal shift: dividend bits plus 4, log2 of 16 (an ORDER_W-bit order stays below 16)
    localparam int SH  = CW + 4;
    localparam int PRW = CW + SH;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_WR, S_UP_RD, S_UP_CMP, S_UP_WR,
        S_RM_RD, S_RM_WR, S_DN_RD, S_DN_CMP, S_DN_WR,
        S_SC_RD, S_SC_CMP, S_MIN_RD, S_MIN_WAIT, S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] cnt_reg;
    logic [OW-1:0] order_reg;
    logic [AW-1:0] pos_reg, oth_reg, best_reg;
    logic [CW-1:0] idx_reg;
    logic [OW-1:0] ch_reg;
    logic signed [KEY_W-1:0] cur_reg, best_key_reg, key_reg, new_reg;
    kind_t kind_reg;
    logic up_reg;
    logic ov_reg;
    logic signed [KEY_W-1:0] res_reg;
    logic [STAT_W-1:0] stat_reg;
    logic out_v_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic we;
    logic [AW-1:0] addr;
    logic [KEY_W-1:0] wdata, rdata;
    logic signed [KEY_W-1:0] rkey;

    dheap_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );
    assign rkey = signed'(rdata);

    // parent = (pos-1)/order by multiplying with a rounded-up reciprocal of the order
    logic [AW-1:0] parent;
    logic [PW-1:0] first_child;
    always_comb
    begin
        logic [CW-1:0] pm1;
        logic [SH-1:0] recip;
        logic [PRW-1:0] prod;
        pm1 = CW'(pos_reg) - 1'b1;
        recip = '0;
        for (int i = 2; i <= MAX_ORDER; i++)
            if (OW'(i) == order_reg)
                recip = SH'(((64'd1 << SH) + 64'(i) - 64'd1) / 64'(i));
        prod = PRW'(pm1) * PRW'(recip);
        parent = AW'(prod >> SH);
        first_child = PW'(pos_reg) * PW'(order_reg) + PW'(1);
    end

    logic [PW-1:0] child_idx;
    assign child_idx = first_child + PW'(ch_reg);

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = out_v_reg;
    assign out_ch.result_key = out_key_reg;
    assign out_ch.status = out_stat_reg;
    assign out_ch.fill_count = out_fill_reg;

    always_comb
    begin
        we = 1'b0;
        addr = pos_reg;
        wdata = cur_reg;
        unique case (state_reg)
            S_INS_WR:   begin we = 1'b1; addr = pos_reg; wdata = key_reg; end
            S_UP_RD:    addr = parent;
            S_UP_WR:    begin we = 1'b1; addr = pos_reg; wdata = best_key_reg; end
            S_RM_RD:    addr = AW'(cnt_reg);
            S_RM_WR:    begin we = 1'b1; addr = '0; wdata = cur_reg; end
            S_DN_RD:    addr = AW'(child_idx);
            S_DN_WR:    begin we = 1'b1; addr = pos_reg; wdata = best_key_reg; end
            S_SC_RD:    addr = AW'(idx_reg);
            S_MIN_RD:   addr = '0;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            order_reg <= OW'(ORDER_RESET);
            out_v_reg <= 1'b0;
            out_key_reg <= '0;
            out_stat_reg <= '0;
            out_fill_reg <= '0;
            ov_reg <= 1'b0;
            up_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_v_reg || out_ch.ready))
            begin
                out_v_reg <= 1'b1;
                out_key_reg <= res_reg;
                out_stat_reg <= stat_reg;
                out_fill_reg <= FILL_W'(cnt_reg);
            end
            else if (out_v_reg && out_ch.ready)
                out_v_reg <= 1'b0;
            if (cfg_we && cnt_reg == '0)
            begin
                if (cfg_wdata < 4'd2)
                    order_reg <= OW'(2);
                else if (32'(cfg_wdata) > MAX_ORDER)
                    order_reg <= OW'(MAX_ORDER);
                else
                    order_reg <= OW'(cfg_wdata);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        kind_reg <= kind_t'(in_ch.kind);
                        key_reg <= in_ch.key;
                        new_reg <= in_ch.new_key;
                        stat_reg <= ST_OK;
                        unique case (kind_t'(in_ch.kind))
                            KIND_INSERT:
                                if (cnt_reg == CW'(CAPACITY))
                                begin
                                    stat_reg <= ST_FULL;
                                    state_reg <= S_MIN_RD;
                                end
                                else
                                begin
                                    pos_reg <= AW'(cnt_reg);
                                    cnt_reg <= cnt_reg + 1'b1;
                                    state_reg <= S_INS_WR;
                                end
                            KIND_PEEK, KIND_REMOVE:
                                if (cnt_reg == '0)
                                begin
                                    stat_reg <= ST_EMPTY;
                                    state_reg <= S_MIN_RD;
                                end
                                else
                                    state_reg <= S_MIN_RD;
                            default:
                            begin
                                idx_reg <= '0;
                                state_reg <= S_SC_RD;
                            end
                        endcase
                    end
                end
                S_INS_WR:
                begin
                    cur_reg <= key_reg;
                    state_reg <= (pos_reg == '0) ? S_MIN_RD : S_UP_RD;
                end
                S_UP_RD: state_reg <= S_UP_CMP;
                S_UP_CMP:
                begin
                    if (cur_reg < rkey)
                    begin
                        best_key_reg <= rkey;
                        oth_reg <= parent;
                        state_reg <= S_UP_WR;
                    end
                    else
                    begin
                        best_key_reg <= cur_reg;
                        oth_reg <= pos_reg;
                        ov_reg <= 1'b1;
                        state_reg <= S_UP_WR;
                    end
                end
                S_UP_WR:
                begin
                    // parent value moved down (or cur written home), continue at parent
                    if (ov_reg)
                    begin
                        ov_reg <= 1'b0;
                        state_reg <= S_MIN_RD;
                    end
                    else
                    begin
                        pos_reg <= oth_reg;
                        if (oth_reg == '0)
                        begin
                            best_key_reg <= cur_reg;
                            ov_reg <= 1'b1;
                            state_reg <= S_UP_WR;
                        end
                        else
                            state_reg <= S_UP_RD;
                    end
                end
                S_RM_RD:
                begin
                    state_reg <= S_RM_WR;
                end
                S_RM_WR:
                begin
                    state_reg <= S_RM_WR;
                    if (!up_reg)
                    begin
                        cur_reg <= rkey;
                        up_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= '0;
                        up_reg <= 1'b0;
                        ch_reg <= '0;
                        best_key_reg <= cur_reg;
                        best_reg <= '0;
                        state_reg <= S_DN_RD;
                    end
                end
                S_DN_RD:
                begin
                    if (child_idx >= PW'(cnt_reg) || ch_reg == order_reg)
                    begin
                        if (best_reg == pos_reg)
                        begin
                            best_key_reg <= cur_reg;
                            ov_reg <= 1'b1;
                        end
                        oth_reg <= best_reg;
                        state_reg <= S_DN_WR;
                    end
                    else
                        state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (rkey < best_key_reg)
                    begin
                        best_key_reg <= rkey;
                        best_reg <= AW'(child_idx);
                    end
                    ch_reg <= ch_reg + 1'b1;
                    state_reg <= S_DN_RD;
                end
                S_DN_WR:
                begin
                    if (ov_reg)
                    begin
                        ov_reg <= 1'b0;
                        // a remove already holds the old minimum as its result
                        state_reg <= (kind_reg == KIND_REMOVE) ? S_DONE : S_MIN_RD;
                    end
                    else
                    begin
                        pos_reg <= oth_reg;
                        best_reg <= oth_reg;
                        best_key_reg <= cur_reg;
                        ch_reg <= '0;
                        state_reg <= S_DN_RD;
                    end
                end
                S_SC_RD:
                begin
                    if (idx_reg == cnt_reg)
                    begin
                        stat_reg <= ST_NOTFOUND;
                        state_reg <= S_MIN_RD;
                    end
                    else
                        state_reg <= S_SC_CMP;
                end
                S_SC_CMP:
                begin
                    if (rkey == key_reg)
                    begin
                        pos_reg <= AW'(idx_reg);
                        cur_reg <= new_reg;
                        if (new_reg > key_reg)
                        begin
                            best_reg <= AW'(idx_reg);
                            best_key_reg <= new_reg;
                            ch_reg <= '0;
                            state_reg <= S_DN_RD;
                        end
                        else if (idx_reg == '0)
                        begin
                            best_key_reg <= new_reg;
                            ov_reg <= 1'b1;
                            state_reg <= S_UP_WR;
                        end
                        else
                            state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_SC_RD;
                    end
                end
                S_MIN_RD: state_reg <= S_MIN_WAIT;
                S_MIN_WAIT:
                begin
                    // remove: min captured, then start the removal
                    if (kind_reg == KIND_REMOVE && stat_reg == ST_OK && !up_reg
                        && !ov_reg)
                    begin
                        res_reg <= rkey;
                        cnt_reg <= cnt_reg - 1'b1;
                        ov_reg <= 1'b1;
                        if (cnt_reg == CW'(1))
                            state_reg <= S_DONE;
                        else
                        begin
                            up_reg <= 1'b0;
                            state_reg <= S_RM_RD;
                        end
                    end
                    else
                    begin
                        if (!(kind_reg == KIND_REMOVE && stat_reg == ST_OK))
                            res_reg <= (cnt_reg == '0) ? KEY_MAX : rkey;
                        ov_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    ov_reg <= 1'b0;
                    up_reg <= 1'b0;
                    if (!out_v_reg || out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_RM_RD)
                ov_reg <= 1'b0;
        end
    end
endmodule

// ===== hw/rtl/dheap_check.sv =====
// Port-level checker for the heap queue, bound to the top level.
`timescale 1ns / 1ps
module dheap_check
    import dheap_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [STAT_W-1:0] out_status,
    input logic [FILL_W-1:0] out_fill,
    input logic signed [KEY_W-1:0] out_key
);
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key))
        else $error("result dropped under stall");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_EMPTY |-> out_key == KEY_MAX && out_fill == '0)
        else $error("empty result malformed");
    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_fill == '0 && out_status == ST_NOTFOUND |-> out_key == KEY_MAX)
        else $error("empty heap reported a key");
endmodule

bind d_ary_min_heap_queue dheap_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.status), .out_fill(out_ch.fill_count),
    .out_key(out_ch.result_key)
);
